### sv/mrt_pkg.sv
// Shared types, constants and codes for the mesh route table.
package mrt_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned COST_W   = 8;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned ENTRIES_DEF        = 16;
  localparam int unsigned ADDR_NONE_DEF      = 0;
  localparam int unsigned ADDR_BROADCAST_DEF = 65535;

  localparam logic [CLASS_W-1:0] CLASS_MISS = 8'hFF;
  localparam logic [COST_W-1:0]  COST_MISS  = 8'h00;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_HIT      = 3'd0,
    STATUS_MISS     = 3'd1,
    STATUS_INSERTED = 3'd2,
    STATUS_UPDATED  = 3'd3,
    STATUS_KEPT     = 3'd4,
    STATUS_REJECTED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_OUT
  } state_e;

  // One stored route, as held in the route RAM.
  typedef struct packed {
    logic [ADDR_W-1:0]  dest;
    logic [ADDR_W-1:0]  hop;
    logic [CLASS_W-1:0] cls;
    logic [COST_W-1:0]  cost;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Scan outcome handed from the search unit to the sequencer.
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

### sv/mrt_req_if.sv
// Request channel: command and route fields with valid/ready.
interface mrt_req_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [mrt_pkg::ADDR_W-1:0]      dest;
  logic [mrt_pkg::ADDR_W-1:0]      next_hop;
  logic [mrt_pkg::CLASS_W-1:0]     traffic_class;
  logic [mrt_pkg::COST_W-1:0]      route_cost;

  modport source (output valid, command, dest, next_hop, traffic_class, route_cost,
                  input ready);
  modport sink   (input valid, command, dest, next_hop, traffic_class, route_cost,
                  output ready);
endinterface

### sv/mrt_rsp_if.sv
// Response channel: status and found route fields with valid/ready.
interface mrt_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [mrt_pkg::STATUS_W-1:0]    status;
  logic [mrt_pkg::ADDR_W-1:0]      found_hop;
  logic [mrt_pkg::CLASS_W-1:0]     found_class;
  logic [mrt_pkg::COST_W-1:0]      found_cost;

  modport source (output valid, status, found_hop, found_class, found_cost,
                  input ready);
  modport sink   (input valid, status, found_hop, found_class, found_cost,
                  output ready);
endinterface

### sv/mrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### sv/mrt_scan.sv
// Serial key search: one RAM read issued and one key compare per cycle.
module mrt_scan #(
  parameter int unsigned ENTRIES = mrt_pkg::ENTRIES_DEF,
  localparam int unsigned IdxW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CntW   = $clog2(ENTRIES + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mrt_pkg::ADDR_W-1:0] key_i,
  input  logic [CntW-1:0]            fill_i,
  input  mrt_pkg::entry_t            rdata_i,
  output logic [IdxW-1:0]            raddr_o,
  output mrt_pkg::scan_res_t         res_o,
  output logic [IdxW-1:0]            slot_o,
  output mrt_pkg::entry_t            entry_o
);
  logic            active_q;
  logic [CntW-1:0] rd_idx_q;
  logic            pend_q;
  logic [IdxW-1:0] pend_idx_q;
  logic            issue;
  logic            match;
  logic            done;

  // Reads run one slot ahead of the compare (RAM read latency).
  assign issue   = active_q && (rd_idx_q < fill_i);
  assign raddr_o = rd_idx_q[IdxW-1:0];
  assign match   = pend_q && (rdata_i.dest == key_i);
  assign done    = active_q && (match || (rd_idx_q == fill_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      rd_idx_q   <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      res_o      <= '0;
    end else begin
      res_o.done <= done;
      if (done) begin
        res_o.hit <= match;
      end
      if (start_i) begin
        active_q <= 1'b1;
        rd_idx_q <= '0;
        pend_q   <= 1'b0;
      end else if (done) begin
        active_q <= 1'b0;
        pend_q   <= 1'b0;
      end else if (active_q) begin
        pend_q     <= issue;
        pend_idx_q <= rd_idx_q[IdxW-1:0];
        if (issue) begin
          rd_idx_q <= rd_idx_q + CntW'(1);
        end
      end
    end
  end

  // Found slot and its contents; no reset needed.
  always_ff @(posedge clk_i) begin
    if (done) begin
      slot_o  <= pend_idx_q;
      entry_o <= rdata_i;
    end
  end
endmodule

### sv/mesh_route_table_unit.sv
// Top level of the mesh route table: sequencer, route RAM, config and result registers.
//
//   channel   dir  handshake      payload
//   req_i     in   valid/ready    command, dest, next_hop, traffic_class, route_cost
//   rsp_o     out  valid/ready    status, found_hop, found_class, found_cost
//   cfg       in   cfg_we_i       cfg_wdata_i -> own_address
//
// One item at a time. A reserved-address add goes from accept straight to its result.
// A miss or an insert runs through accept, one RAM read and key compare per stored route
// (at most ENTRIES are stored) behind the RAM read latency, a registered scan result and
// a resolve/write-back step; a found key ends the scan at its slot.
// A result holds on rsp_o until taken; req_i.ready is low meanwhile. Reset: async,
// active low; clears fill count, insert pointer, own_address, sequencer; RAM is not.
module mesh_route_table_unit #(
  parameter int unsigned ENTRIES        = mrt_pkg::ENTRIES_DEF,
  parameter int unsigned ADDR_NONE      = mrt_pkg::ADDR_NONE_DEF,
  parameter int unsigned ADDR_BROADCAST = mrt_pkg::ADDR_BROADCAST_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mrt_req_if.sink                    req_i,
  mrt_rsp_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [mrt_pkg::ADDR_W-1:0] cfg_wdata_i
);
  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam logic [mrt_pkg::ADDR_W-1:0] AddrNone  = mrt_pkg::ADDR_W'(ADDR_NONE);
  localparam logic [mrt_pkg::ADDR_W-1:0] AddrBcast = mrt_pkg::ADDR_W'(ADDR_BROADCAST);

  mrt_pkg::state_e state_q, state_d;

  // Configuration
  logic [mrt_pkg::ADDR_W-1:0] own_q;

  // Latched request
  logic                        cmd_q;
  logic [mrt_pkg::ADDR_W-1:0]  dest_q;
  logic [mrt_pkg::ADDR_W-1:0]  hop_q;
  logic [mrt_pkg::CLASS_W-1:0] cls_q;
  logic [mrt_pkg::COST_W-1:0]  cost_q;

  // Table bookkeeping: slots below fill_q are valid (inserts go in order and wrap
  // only once the table is full, so a fill count stands in for per-slot valid bits).
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] ptr_q, ptr_d;

  // Result register
  logic [mrt_pkg::STATUS_W-1:0] status_q, status_d;
  logic [mrt_pkg::ADDR_W-1:0]   ohop_q, ohop_d;
  logic [mrt_pkg::CLASS_W-1:0]  ocls_q, ocls_d;
  logic [mrt_pkg::COST_W-1:0]   ocost_q, ocost_d;

  // RAM and search unit
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  mrt_pkg::entry_t    ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  mrt_pkg::entry_t    ram_rdata;
  logic               scan_start;
  mrt_pkg::scan_res_t scan_res;
  logic [IdxW-1:0]    scan_slot;
  mrt_pkg::entry_t    scan_entry;

  logic req_acc;
  logic reserved;

  assign req_acc  = req_i.valid && req_i.ready;
  assign reserved = (req_i.dest == own_q) || (req_i.dest == AddrBcast) ||
                    (req_i.dest == AddrNone);

  mrt_ram #(
    .WIDTH (mrt_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mrt_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scan_start),
    .key_i   (dest_q),
    .fill_i  (fill_q),
    .rdata_i (ram_rdata),
    .raddr_o (ram_raddr),
    .res_o   (scan_res),
    .slot_o  (scan_slot),
    .entry_o (scan_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mrt_pkg::ST_IDLE;
      own_q   <= '0;
      fill_q  <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ptr_q   <= ptr_d;
      if (cfg_we_i) begin
        own_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q  <= req_i.command;
      dest_q <= req_i.dest;
      hop_q  <= req_i.next_hop;
      cls_q  <= req_i.traffic_class;
      cost_q <= req_i.route_cost;
    end
    status_q <= status_d;
    ohop_q   <= ohop_d;
    ocls_q   <= ocls_d;
    ocost_q  <= ocost_d;
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    status_d   = status_q;
    ohop_d     = ohop_q;
    ocls_d     = ocls_q;
    ocost_d    = ocost_q;
    scan_start = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = '{dest: dest_q, hop: hop_q, cls: cls_q, cost: cost_q};
    req_i.ready = 1'b0;
    rsp_o.valid = 1'b0;

    case (state_q)
      mrt_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_acc) begin
          // Every add result carries the miss defaults in its route fields.
          ohop_d  = AddrNone;
          ocls_d  = mrt_pkg::CLASS_MISS;
          ocost_d = mrt_pkg::COST_MISS;
          if (req_i.command == mrt_pkg::CMD_ADD && reserved) begin
            status_d = mrt_pkg::STATUS_REJECTED;
            state_d  = mrt_pkg::ST_OUT;
          end else begin
            scan_start = 1'b1;
            state_d    = mrt_pkg::ST_SCAN;
          end
        end
      end

      mrt_pkg::ST_SCAN: begin
        if (scan_res.done) begin
          state_d = mrt_pkg::ST_RESOLVE;
        end
      end

      mrt_pkg::ST_RESOLVE: begin
        state_d = mrt_pkg::ST_OUT;
        if (cmd_q == mrt_pkg::CMD_LOOKUP) begin
          if (scan_res.hit) begin
            status_d = mrt_pkg::STATUS_HIT;
            ohop_d   = scan_entry.hop;
            ocls_d   = scan_entry.cls;
            ocost_d  = scan_entry.cost;
          end else begin
            status_d = mrt_pkg::STATUS_MISS;
          end
        end else if (scan_res.hit) begin
          // Replace only when the new cost is not worse.
          if (scan_entry.cost >= cost_q) begin
            ram_we    = 1'b1;
            ram_waddr = scan_slot;
            status_d  = mrt_pkg::STATUS_UPDATED;
          end else begin
            status_d = mrt_pkg::STATUS_KEPT;
          end
        end else begin
          // New route into the round-robin slot.
          ram_we   = 1'b1;
          status_d = mrt_pkg::STATUS_INSERTED;
          ptr_d    = (ptr_q == IdxW'(ENTRIES - 1)) ? '0 : ptr_q + IdxW'(1);
          if (fill_q != CntW'(ENTRIES)) begin
            fill_d = fill_q + CntW'(1);
          end
        end
      end

      mrt_pkg::ST_OUT: begin
        rsp_o.valid = 1'b1;
        if (rsp_o.ready) begin
          state_d = mrt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mrt_pkg::ST_IDLE;
      end
    endcase
  end

  assign rsp_o.status      = status_q;
  assign rsp_o.found_hop   = ohop_q;
  assign rsp_o.found_class = ocls_q;
  assign rsp_o.found_cost  = ocost_q;

  // Never take a new item while a result is waiting.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("request accepted while result pending");

  // Fill count stays within the table.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(ENTRIES))
    else $error("fill count beyond table size");

  // Table is written only on the resolve step of an add.
  a_write_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == mrt_pkg::ST_RESOLVE && cmd_q == mrt_pkg::CMD_ADD))
    else $error("route write outside add resolve");

  // Hit and miss are lookup results only.
  a_hit_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (status_q == mrt_pkg::STATUS_HIT || status_q == mrt_pkg::STATUS_MISS))
    |-> cmd_q == mrt_pkg::CMD_LOOKUP)
    else $error("lookup status on add item");

  // An insert advances the pointer by one slot.
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mrt_pkg::ST_RESOLVE && cmd_q == mrt_pkg::CMD_ADD && !scan_res.hit)
    |=> ptr_q == (($past(ptr_q) == IdxW'(ENTRIES - 1)) ? '0 : $past(ptr_q) + IdxW'(1)))
    else $error("insert pointer did not advance");

endmodule

### tb/tb_mesh_route_table_unit.sv
// Self-checking testbench for the mesh route table: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_mesh_route_table_unit;

  // Cycle budget: about 2000 items, each scanning up to ENTRIES routes, random gaps on
  // both sides and one long receiver hold-off. The limit sits far above that.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 2 * (mrt_pkg::ENTRIES_DEF + 4);
  localparam int unsigned TABLE_SLOTS  = mrt_pkg::ENTRIES_DEF;
  localparam int unsigned KEYS         = 24;   // more keys than slots, so the table wraps
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_ITEMS  = 400;
  localparam int unsigned HOLD_CYCLES  = 400;

  localparam logic [mrt_pkg::ADDR_W-1:0] NO_ADDR =
    mrt_pkg::ADDR_W'(mrt_pkg::ADDR_NONE_DEF);
  localparam logic [mrt_pkg::ADDR_W-1:0] BCAST   =
    mrt_pkg::ADDR_W'(mrt_pkg::ADDR_BROADCAST_DEF);

  typedef struct packed {
    mrt_pkg::cmd_e               cmd;
    logic [mrt_pkg::ADDR_W-1:0]  dest;
    logic [mrt_pkg::ADDR_W-1:0]  hop;
    logic [mrt_pkg::CLASS_W-1:0] cls;
    logic [mrt_pkg::COST_W-1:0]  cost;
  } route_req_t;

  typedef struct packed {
    mrt_pkg::status_e            status;
    logic [mrt_pkg::ADDR_W-1:0]  hop;
    logic [mrt_pkg::CLASS_W-1:0] cls;
    logic [mrt_pkg::COST_W-1:0]  cost;
  } route_rsp_t;

  // A directed row is either an item or a write of own_address (taken from dest).
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    route_req_t req;
    logic       pinned;  // want holds the expected result, else the predictor decides
    route_rsp_t want;
  } plan_row_t;

  localparam route_rsp_t NO_RSP  =
    '{mrt_pkg::STATUS_MISS, NO_ADDR, mrt_pkg::CLASS_MISS, mrt_pkg::COST_MISS};
  localparam route_rsp_t REJECT  =
    '{mrt_pkg::STATUS_REJECTED, NO_ADDR, mrt_pkg::CLASS_MISS, mrt_pkg::COST_MISS};
  localparam route_rsp_t INSERT  =
    '{mrt_pkg::STATUS_INSERTED, NO_ADDR, mrt_pkg::CLASS_MISS, mrt_pkg::COST_MISS};
  localparam route_rsp_t UPDATE  =
    '{mrt_pkg::STATUS_UPDATED, NO_ADDR, mrt_pkg::CLASS_MISS, mrt_pkg::COST_MISS};
  localparam route_rsp_t KEEP    =
    '{mrt_pkg::STATUS_KEPT, NO_ADDR, mrt_pkg::CLASS_MISS, mrt_pkg::COST_MISS};

  localparam int unsigned PLAN_ROWS = 25;

  // Directed part: empty-table lookups, reserved-address adds, field extremes,
  // update on equal and lower cost, kept on higher cost, and a route that becomes
  // the node's own address after it was stored.
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_CFG,  '{mrt_pkg::CMD_ADD,    16'h1234, 16'h0000, 8'h00, 8'h00}, 1'b0, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h0001, 16'h0000, 8'h00, 8'h00}, 1'b1, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'h00, 8'h00}, 1'b1, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h0000, 16'hBEEF, 8'h11, 8'h22}, 1'b1, REJECT},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'hFFFF, 16'hBEEF, 8'h11, 8'h22}, 1'b1, REJECT},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h1234, 16'hBEEF, 8'h11, 8'h22}, 1'b1, REJECT},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h0001, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, INSERT},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h0001, 16'h0000, 8'h00, 8'h00}, 1'b1,
      '{mrt_pkg::STATUS_HIT, 16'hFFFF, 8'hFF, 8'hFF}},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h0001, 16'h0000, 8'h00, 8'hFF}, 1'b1, UPDATE},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h0001, 16'hAAAA, 8'h55, 8'h00}, 1'b1, UPDATE},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h0001, 16'h5555, 8'hAA, 8'h01}, 1'b1, KEEP},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h0001, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1,
      '{mrt_pkg::STATUS_HIT, 16'hAAAA, 8'h55, 8'h00}},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'hFFFE, 16'h0001, 8'h80, 8'h7F}, 1'b1, INSERT},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'hFFFE, 16'h0000, 8'h00, 8'h00}, 1'b1,
      '{mrt_pkg::STATUS_HIT, 16'h0001, 8'h80, 8'h7F}},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h2222, 16'h1111, 8'h01, 8'h02}, 1'b1, INSERT},
    '{ROW_CFG,  '{mrt_pkg::CMD_ADD,    16'h2222, 16'h0000, 8'h00, 8'h00}, 1'b0, NO_RSP},
    // own address now has a stored route: lookup still finds it, add is refused
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h2222, 16'h0000, 8'h00, 8'h00}, 1'b1,
      '{mrt_pkg::STATUS_HIT, 16'h1111, 8'h01, 8'h02}},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h2222, 16'h3333, 8'h00, 8'h00}, 1'b1, REJECT},
    '{ROW_CFG,  '{mrt_pkg::CMD_ADD,    16'hFFFF, 16'h0000, 8'h00, 8'h00}, 1'b0, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h1234, 16'h0F0F, 8'hF0, 8'h80}, 1'b1, INSERT},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h00, 8'h00}, 1'b0, NO_RSP},
    '{ROW_CFG,  '{mrt_pkg::CMD_ADD,    16'h0000, 16'h0000, 8'h00, 8'h00}, 1'b0, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_ADD,    16'h0002, 16'h8000, 8'h7F, 8'h10}, 1'b0, NO_RSP},
    '{ROW_ITEM, '{mrt_pkg::CMD_LOOKUP, 16'h0002, 16'h0000, 8'h00, 8'h00}, 1'b0, NO_RSP}
  };

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [mrt_pkg::ADDR_W-1:0] cfg_wdata_i;

  mrt_req_if req_if ();
  mrt_rsp_if rsp_if ();

  mesh_route_table_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predicted table contents and configuration, updated as items are accepted.
  logic [mrt_pkg::ADDR_W-1:0]  rt_dest [TABLE_SLOTS];
  logic [mrt_pkg::ADDR_W-1:0]  rt_hop  [TABLE_SLOTS];
  logic [mrt_pkg::CLASS_W-1:0] rt_cls  [TABLE_SLOTS];
  logic [mrt_pkg::COST_W-1:0]  rt_cost [TABLE_SLOTS];
  bit                          rt_valid[TABLE_SLOTS];
  int unsigned                 rt_ptr = 0;
  logic [mrt_pkg::ADDR_W-1:0]  own_addr = '0;

  route_rsp_t                  route_answers_q[$];  // results still owed, oldest first
  route_rsp_t                  head_rsp;
  logic [mrt_pkg::ADDR_W-1:0]  key_pool[KEYS];
  int unsigned                 mismatch_cnt = 0;
  int unsigned                 cycle_cnt = 0;
  bit                          gaps_on = 1'b1;   // random idling on both sides
  bit                          hold_ask = 1'b0;  // sender asks for a long hold-off
  int unsigned                 hold_left = 0;

  // Expected result of one item; stores the route changes it makes.
  function automatic route_rsp_t resolve_route(input route_req_t r);
    route_rsp_t ans;
    int slot;
    ans = NO_RSP;
    slot = -1;
    // lowest valid slot with a matching key wins
    for (int i = 0; i < TABLE_SLOTS; i++)
      if (slot < 0 && rt_valid[i] && rt_dest[i] == r.dest) slot = i;
    if (r.cmd == mrt_pkg::CMD_LOOKUP) begin
      if (slot >= 0) begin
        ans.status = mrt_pkg::STATUS_HIT;
        ans.hop    = rt_hop[slot];
        ans.cls    = rt_cls[slot];
        ans.cost   = rt_cost[slot];
      end
    end else if (r.dest == own_addr || r.dest == BCAST || r.dest == NO_ADDR) begin
      ans.status = mrt_pkg::STATUS_REJECTED;
    end else if (slot >= 0) begin
      // update on equal or lower cost
      if (rt_cost[slot] >= r.cost) begin
        rt_hop[slot]  = r.hop;
        rt_cls[slot]  = r.cls;
        rt_cost[slot] = r.cost;
        ans.status    = mrt_pkg::STATUS_UPDATED;
      end else begin
        ans.status = mrt_pkg::STATUS_KEPT;
      end
    end else begin
      // round-robin slot, valid or not
      rt_dest[rt_ptr]  = r.dest;
      rt_hop[rt_ptr]   = r.hop;
      rt_cls[rt_ptr]   = r.cls;
      rt_cost[rt_ptr]  = r.cost;
      rt_valid[rt_ptr] = 1'b1;
      rt_ptr           = (rt_ptr + 1) % TABLE_SLOTS;
      ans.status       = mrt_pkg::STATUS_INSERTED;
    end
    return ans;
  endfunction

  // Random item: mostly keys from a small pool so hits, updates and evictions occur.
  function automatic route_req_t random_route_req();
    route_req_t r;
    int unsigned pick;
    r.cmd = ($urandom_range(1) != 0) ? mrt_pkg::CMD_LOOKUP : mrt_pkg::CMD_ADD;
    pick  = $urandom_range(99);
    if (pick < 75) begin
      r.dest = key_pool[$urandom_range(KEYS - 1)];
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0:       r.dest = NO_ADDR;
        1:       r.dest = BCAST;
        default: r.dest = own_addr;
      endcase
    end else begin
      r.dest = mrt_pkg::ADDR_W'($urandom_range(16'hFFFF));
    end
    r.hop  = mrt_pkg::ADDR_W'($urandom_range(16'hFFFF));
    r.cls  = mrt_pkg::CLASS_W'($urandom_range(8'hFF));
    r.cost = mrt_pkg::COST_W'($urandom_range(8'hFF));
    return r;
  endfunction

  // Offer one item, hold it until accepted, then log what the block owes for it.
  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic offer_route(input route_req_t r, input logic pinned,
                             input route_rsp_t want);
    route_rsp_t predicted;
    while (gaps_on && $urandom_range(99) < 32) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.command       <= r.cmd;
    req_if.dest          <= r.dest;
    req_if.next_hop      <= r.hop;
    req_if.traffic_class <= r.cls;
    req_if.route_cost    <= r.cost;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = resolve_route(r);
    route_answers_q.push_back(pinned ? want : predicted);
  endtask

  // Drain every owed result, then write own_address while the block is idle.
  task automatic set_own_address(input logic [mrt_pkg::ADDR_W-1:0] addr);
    req_if.valid <= 1'b0;
    while (route_answers_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    own_addr     = addr;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run guard: a hung handshake or a result that never comes ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block sits on a result and refuses new items while the sender keeps offering.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (gaps_on) begin
        rsp_if.ready <= ($urandom_range(99) >= 32);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Result check: every taken result against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (route_answers_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: expected no result, got status %0d hop %h class %h cost %h",
                 $realtime, rsp_if.status, rsp_if.found_hop, rsp_if.found_class,
                 rsp_if.found_cost);
      end else begin
        head_rsp = route_answers_q.pop_front();
        if (rsp_if.status !== head_rsp.status || rsp_if.found_hop !== head_rsp.hop ||
            rsp_if.found_class !== head_rsp.cls || rsp_if.found_cost !== head_rsp.cost) begin
          mismatch_cnt++;
          $display("%0t: expected status %0d hop %h class %h cost %h, got %0d %h %h %h",
                   $realtime, head_rsp.status, head_rsp.hop, head_rsp.cls, head_rsp.cost,
                   rsp_if.status, rsp_if.found_hop, rsp_if.found_class, rsp_if.found_cost);
        end
      end
    end
  end

  // Sender and sequencing of the whole run.
  initial begin : stimulus
    logic [mrt_pkg::ADDR_W-1:0] next_own;
    req_if.valid         = 1'b0;
    req_if.command       = mrt_pkg::CMD_ADD;
    req_if.dest          = '0;
    req_if.next_hop      = '0;
    req_if.traffic_class = '0;
    req_if.route_cost    = '0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    rst_ni               = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG)
        set_own_address(PLAN[i].req.dest);
      else
        offer_route(PLAN[i].req, PLAN[i].pinned, PLAN[i].want);
    end

    // Random phases, each behind an idle own_address write (extremes, random,
    // a key the table holds, a pool key). Phase 1 runs without any idling; phase 2
    // gets the long receiver hold-off.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0 || phase == 3)
        foreach (key_pool[k]) key_pool[k] = mrt_pkg::ADDR_W'($urandom_range(16'hFFFF));
      case (phase)
        0: next_own = BCAST;
        3: next_own = NO_ADDR;
        2: begin
          next_own = mrt_pkg::ADDR_W'($urandom_range(16'hFFFF));
          for (int s = TABLE_SLOTS - 1; s >= 0; s--)
            if (rt_valid[s]) next_own = rt_dest[s];
        end
        4: next_own = key_pool[$urandom_range(KEYS - 1)];
        default: next_own = mrt_pkg::ADDR_W'($urandom_range(16'hFFFF));
      endcase
      set_own_address(next_own);
      gaps_on = (phase != 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 60) hold_ask = 1'b1;
        offer_route(random_route_req(), 1'b0, NO_RSP);
      end
    end

    req_if.valid <= 1'b0;
    while (route_answers_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/mrt_pkg.sv
sv/mrt_req_if.sv
sv/mrt_rsp_if.sv
sv/mrt_ram.sv
sv/mrt_scan.sv
sv/mesh_route_table_unit.sv
tb/tb_mesh_route_table_unit.sv
